@@ rtl/minstk_pkg.sv @@
// shared types and codes for the running-minimum stack
package minstk_pkg;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic exec;
      logic load;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic reload;
   } dp_stat_type;

endpackage

@@ rtl/stack_with_running_minimum_unit.sv @@
// top level: LIFO stack of signed words that tracks the minimum of its contents
// a push, or a pop leaving the stack empty, strobes its response in the cycle after start
// a pop that leaves entries first loads the new top from the entry memory
// one request at a time: busy is held high until and during the response strobe
// the response strobe lasts one cycle and the receiver cannot stall it
// synchronous reset empties the stack; memory contents stay undefined until written
module stack_with_running_minimum_unit #(
   parameter int STACK_DEPTH = 64,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_opcode,
   input  logic signed [WORD_WIDTH-1:0]            req_push_value,
   output logic                                    rsp_valid,
   output logic signed [WORD_WIDTH-1:0]            rsp_top_value,
   output logic signed [WORD_WIDTH-1:0]            rsp_min_value,
   output logic [$clog2(STACK_DEPTH+1)-1:0]        rsp_depth,
   output logic                                    rsp_nonempty,
   output logic [1:0]                              rsp_status
);
   import minstk_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   minstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   minstk_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH),
      .CW          (CW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_depth      (rsp_depth),
      .rsp_nonempty   (rsp_nonempty),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTHESIS
   // every accepted request is followed by busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OVERFLOW)) |-> (rsp_depth == CW'(STACK_DEPTH)))
      else $error("overflow reported on a stack that is not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_UNDERFLOW)) |-> (rsp_depth == '0))
      else $error("underflow reported on a stack that is not empty");

   a_min_not_above_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nonempty) |-> (rsp_min_value <= rsp_top_value))
      else $error("minimum above top word");
`endif

endmodule

@@ rtl/minstk_ctrl.sv @@
// controller state machine for the running-minimum stack
module minstk_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   input  minstk_pkg::dp_stat_type  dp_stat,
   output minstk_pkg::dp_cmd_type   dp_cmd
);
   import minstk_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LOAD  = 3'b010,
      S_REPLY = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      dp_cmd.exec = 1'b0;
      dp_cmd.load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.exec = 1'b1;
               // a pop that leaves entries needs the new top fetched from memory
               state_in = dp_stat.reload ? S_LOAD : S_REPLY;
            end
         end
         S_LOAD: begin
            dp_cmd.load = 1'b1;
            state_in    = S_REPLY;
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_REPLY);

endmodule

@@ rtl/minstk_dp.sv @@
// datapath: entry memory, cached top entry, entry count and status
module minstk_dp #(
   parameter int STACK_DEPTH = 64,
   parameter int WORD_WIDTH  = 32,
   parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  minstk_pkg::dp_cmd_type        dp_cmd,
   output minstk_pkg::dp_stat_type       dp_stat,
   input  logic                          req_opcode,
   input  logic signed [WORD_WIDTH-1:0]  req_push_value,
   output logic signed [WORD_WIDTH-1:0]  rsp_top_value,
   output logic signed [WORD_WIDTH-1:0]  rsp_min_value,
   output logic [CW-1:0]                 rsp_depth,
   output logic                          rsp_nonempty,
   output logic [1:0]                    rsp_status
);
   import minstk_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // each entry holds the word and the minimum up to it
   logic [2*WORD_WIDTH-1:0] mem [STACK_DEPTH];

   logic [CW-1:0]                count_ff, count_in;
   status_type                   status_ff, status_in;
   logic signed [WORD_WIDTH-1:0] top_val_ff, top_val_in;
   logic signed [WORD_WIDTH-1:0] top_min_ff, top_min_in;
   logic [2*WORD_WIDTH-1:0]      rd_data_ff;

   logic                         is_pop;
   logic                         full;
   logic                         empty;
   logic                         do_write;
   logic                         do_read;
   logic signed [WORD_WIDTH-1:0] new_min;
   logic [CW-1:0]                rd_index;

   assign is_pop = (req_opcode == OP_POP);
   assign full   = (count_ff == CW'(STACK_DEPTH));
   assign empty  = (count_ff == '0);

   // strict compare: an equal word keeps the minimum below it
   assign new_min = (empty || (req_push_value < top_min_ff)) ? req_push_value : top_min_ff;

   assign do_write = dp_cmd.exec && !is_pop && !full;
   assign do_read  = dp_cmd.exec && dp_stat.reload;
   assign rd_index = count_ff - CW'(2);

   assign dp_stat.reload = is_pop && (count_ff > CW'(1));

   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      if (dp_cmd.exec) begin
         status_in = ST_OK;
         if (!is_pop) begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in   = count_ff + CW'(1);
               top_val_in = req_push_value;
               top_min_in = new_min;
            end
         end else begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
      end else if (dp_cmd.load) begin
         top_val_in = rd_data_ff[2*WORD_WIDTH-1:WORD_WIDTH];
         top_min_in = rd_data_ff[WORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= ST_OK;
      end else begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[count_ff[AW-1:0]] <= {req_push_value, new_min};
      end
      if (do_read) begin
         rd_data_ff <= mem[rd_index[AW-1:0]];
      end
   end

   assign rsp_nonempty  = !empty;
   assign rsp_top_value = empty ? '0 : top_val_ff;
   assign rsp_min_value = empty ? '0 : top_min_ff;
   assign rsp_depth     = count_ff;
   assign rsp_status    = status_ff;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the running-minimum stack
`timescale 1ns / 1ps

module testbench;
   import minstk_pkg::*;

   localparam int DEPTH = 64;
   localparam int WIDTH = 32;
   localparam int RANDOM_REQUESTS = 1000;

   typedef struct {
      logic                    opcode;
      logic signed [WIDTH-1:0] value;
      int                      idle_pct;
      bit                      drain;
   } stack_request_t;

   typedef struct {
      logic signed [WIDTH-1:0] top;
      logic signed [WIDTH-1:0] minimum;
      logic [6:0]              depth;
      logic                    nonempty;
      status_type              status;
   } stack_view_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_opcode = OP_PUSH;
   logic signed [WIDTH-1:0] req_push_value = '0;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_top_value;
   logic signed [WIDTH-1:0] rsp_min_value;
   logic [6:0]              rsp_depth;
   logic                    rsp_nonempty;
   logic [1:0]              rsp_status;

   stack_request_t request_queue[$];
   stack_view_t    pending_views[$];
   stack_request_t next_request;
   stack_view_t    arrived_view;

   // predictor copy of the stack
   logic signed [WIDTH-1:0] word_mem[DEPTH];
   logic signed [WIDTH-1:0] floor_mem[DEPTH];
   logic [6:0]              held_count;

   logic req_taken = 1'b0;
   int   accepted_count = 0;
   int   total_requests = 0;
   int   error_count = 0;

   stack_with_running_minimum_unit #(
      .STACK_DEPTH(DEPTH),
      .WORD_WIDTH (WIDTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_push_value(req_push_value),
      .rsp_valid     (rsp_valid),
      .rsp_top_value (rsp_top_value),
      .rsp_min_value (rsp_min_value),
      .rsp_depth     (rsp_depth),
      .rsp_nonempty  (rsp_nonempty),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic stack_view_t step_stack(input logic opcode,
                                              input logic signed [WIDTH-1:0] value);
      stack_view_t view;
      view.status = ST_OK;
      if (opcode == OP_PUSH) begin
         if (held_count >= DEPTH) begin
            view.status = ST_OVERFLOW;
         end else begin
            // only a strictly smaller word takes over the minimum
            if (held_count > 0 && !(value < floor_mem[held_count-1]))
               floor_mem[held_count] = floor_mem[held_count-1];
            else
               floor_mem[held_count] = value;
            word_mem[held_count] = value;
            held_count++;
         end
      end else begin
         if (held_count == 0)
            view.status = ST_UNDERFLOW;
         else
            held_count--;
      end
      view.depth = held_count;
      view.nonempty = (held_count != 0);
      view.top = view.nonempty ? word_mem[held_count-1] : '0;
      view.minimum = view.nonempty ? floor_mem[held_count-1] : '0;
      return view;
   endfunction

   // driver: new request on the falling edge, held until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         start <= 1'b1;
      end else if (request_queue.size() == 0) begin
         start <= 1'b0;
      end else if (request_queue[0].drain && pending_views.size() != 0) begin
         start <= 1'b0;
      end else if ($urandom_range(99) < request_queue[0].idle_pct) begin
         start <= 1'b0;
      end else begin
         next_request = request_queue.pop_front();
         start <= 1'b1;
         req_opcode <= next_request.opcode;
         req_push_value <= next_request.value;
      end
   end

   // monitor and predictor on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         held_count = '0;
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (pending_views.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_top_value, '0);
            end else begin
               arrived_view = pending_views.pop_front();
               if (rsp_top_value !== arrived_view.top)
                  report_mismatch("top_value", rsp_top_value, arrived_view.top);
               if (rsp_min_value !== arrived_view.minimum)
                  report_mismatch("min_value", rsp_min_value, arrived_view.minimum);
               if (rsp_depth !== arrived_view.depth)
                  report_mismatch("depth", 32'(rsp_depth), 32'(arrived_view.depth));
               if (rsp_nonempty !== arrived_view.nonempty)
                  report_mismatch("nonempty", 32'(rsp_nonempty),
                                  32'(arrived_view.nonempty));
               if (rsp_status !== arrived_view.status)
                  report_mismatch("status", 32'(rsp_status), 32'(arrived_view.status));
            end
         end
         if (start && !busy) begin
            pending_views = {pending_views, step_stack(req_opcode, req_push_value)};
            accepted_count++;
         end
         req_taken <= start && !busy;
      end
   end

   task automatic add_request(input logic opcode, input logic signed [WIDTH-1:0] value,
                              input int idle_pct, input bit drain);
      stack_request_t item;
      item.opcode = opcode;
      item.value = value;
      item.idle_pct = idle_pct;
      item.drain = drain;
      request_queue = {request_queue, item};
      total_requests++;
   endtask

   function automatic logic signed [WIDTH-1:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5)
         return $urandom;
      else if (sel < 8)
         return $signed($urandom_range(16)) - 8; // narrow range makes ties
      else if (sel == 8)
         return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      else
         return $urandom_range(1) ? 32'hffffffff : 32'h0;
   endfunction

   initial begin
      int phase_idle;
      int burst_len;
      int push_pct;
      int issued;
      int mode;

      // directed: empty pops, extreme words, tie on the minimum, drain to empty
      add_request(OP_POP, 32'h0, 30, 1'b0);
      add_request(OP_POP, 32'hffffffff, 30, 1'b0);
      add_request(OP_PUSH, 32'h7fffffff, 30, 1'b0);
      add_request(OP_PUSH, 32'h80000000, 30, 1'b0);
      add_request(OP_PUSH, 32'h80000000, 30, 1'b0);
      add_request(OP_PUSH, 32'h7fffffff, 30, 1'b0);
      add_request(OP_PUSH, 32'hffffffff, 30, 1'b0);
      repeat (5) add_request(OP_POP, 32'h0, 30, 1'b0);
      add_request(OP_POP, 32'h5a5a5a5a, 30, 1'b0);
      add_request(OP_PUSH, 32'd5, 0, 1'b1);
      add_request(OP_PUSH, 32'd3, 0, 1'b0);
      add_request(OP_PUSH, 32'd3, 0, 1'b0);
      add_request(OP_PUSH, 32'd7, 0, 1'b0);
      add_request(OP_PUSH, -32'sd2, 0, 1'b0);
      add_request(OP_PUSH, 32'h0, 0, 1'b0);
      repeat (3) add_request(OP_POP, 32'h0, 0, 1'b0);

      // random bursts that climb to full, fall to empty or wander
      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         mode = $urandom_range(2);
         burst_len = $urandom_range(100, 10);
         push_pct = (mode == 0) ? 90 : (mode == 1) ? 12 : 50;
         for (int k = 0; k < burst_len && issued < RANDOM_REQUESTS; k++) begin
            // phases: no gaps, heavy gaps, no gaps, light gaps
            case ((issued * 4) / RANDOM_REQUESTS)
               1: phase_idle = 68;
               3: phase_idle = 22;
               default: phase_idle = 0;
            endcase
            add_request($urandom_range(99) < push_pct ? OP_PUSH : OP_POP, pick_value(),
                        phase_idle,
                        (issued % (RANDOM_REQUESTS / 4) == 0) || ($urandom_range(99) < 2));
            issued++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || pending_views.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
